// ===== rtl/vzd_pkg.sv =====
// ----------------------------------------------------------------------------
// vzd_pkg
// Shared types and constants for the varint zigzag decoder.
// ----------------------------------------------------------------------------
package vzd_pkg;

   // Default limit on bytes per varint
   localparam int MAX_BYTES_DEF = 10;

   // Payload bits carried by one encoded byte
   localparam int PAYLOAD_W = 7;

   // Width of the decoded value and of the byte count
   localparam int VALUE_W = 64;
   localparam int COUNT_W = 4;

   // Depth of the queue between the classifier and the accumulator
   localparam int QUEUE_DEPTH = 2;

   // Bit position of the continuation flag in an encoded byte
   localparam int CONT_BIT = 7;

   // How a varint ended
   typedef enum logic [1:0] {
      END_TERM   = 2'd0,
      END_BUFFER = 2'd1,
      END_LIMIT  = 2'd2
   } reason_type;

   // One classified byte, handed from the front to the back
   typedef struct packed {
      logic [PAYLOAD_W-1:0] payload;
      logic [COUNT_W-1:0]   idx;
      logic                 is_end;
      reason_type           reason;
   } op_type;

endpackage

// ===== rtl/vzd_front.sv =====
// ----------------------------------------------------------------------------
// vzd_front
// Byte classifier: tracks the position within the current varint and decides
// whether the byte ends it and why.
// ----------------------------------------------------------------------------
module vzd_front #(
   parameter int MAX_BYTES = vzd_pkg::MAX_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             byte_valid,
   output logic                             byte_ready,
   input  logic [7:0]                       data_byte,
   input  logic                             buffer_end,
   output logic                             op_valid,
   input  logic                             op_ready,
   output vzd_pkg::op_type                  op
);

   logic [vzd_pkg::COUNT_W-1:0] count_ff;
   logic [vzd_pkg::COUNT_W-1:0] count_in;
   logic [vzd_pkg::COUNT_W-1:0] used;
   logic                        take;

   assign byte_ready = op_ready;
   assign op_valid   = byte_valid;
   assign take       = byte_valid && op_ready;
   assign used       = count_ff + vzd_pkg::COUNT_W'(1);

   // Classify: terminator beats buffer end, buffer end beats the byte limit
   always_comb begin
      op.payload = data_byte[vzd_pkg::PAYLOAD_W-1:0];
      op.idx     = count_ff;
      op.is_end  = 1'b1;
      op.reason  = vzd_pkg::END_TERM;
      priority if (!data_byte[vzd_pkg::CONT_BIT]) begin
         op.reason = vzd_pkg::END_TERM;
      end else if (buffer_end) begin
         op.reason = vzd_pkg::END_BUFFER;
      end else if (used >= vzd_pkg::COUNT_W'(MAX_BYTES)) begin
         op.reason = vzd_pkg::END_LIMIT;
      end else begin
         op.is_end = 1'b0;
      end
   end

   // Advance the position, restart after an ending byte
   always_comb begin
      count_in = count_ff;
      if (take) begin
         count_in = op.is_end ? '0 : used;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/vzd_queue.sv =====
// ----------------------------------------------------------------------------
// vzd_queue
// Short first-in first-out queue of classified bytes.
// ----------------------------------------------------------------------------
module vzd_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   output logic            push_ready,
   input  vzd_pkg::op_type push_op,
   output logic            pop_valid,
   input  logic            pop_ready,
   output vzd_pkg::op_type pop_op
);

   localparam int DEPTH = vzd_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   vzd_pkg::op_type  entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] fill_ff;
   logic [CNT_W-1:0] fill_in;
   logic             push;
   logic             pop;

   assign push_ready = (fill_ff != CNT_W'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_op     = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== rtl/vzd_back.sv =====
// ----------------------------------------------------------------------------
// vzd_back
// Accumulator and result stage: merges payload bits at the byte's shift,
// applies zigzag in signed mode and holds the result until it is taken.
// ----------------------------------------------------------------------------
module vzd_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              op_valid,
   output logic                              op_ready,
   input  vzd_pkg::op_type                   op,
   input  logic                              mode_wr,
   input  logic                              mode_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [vzd_pkg::VALUE_W-1:0]       rsp_value,
   output logic [vzd_pkg::COUNT_W-1:0]       rsp_used,
   output vzd_pkg::reason_type               rsp_reason
);

   localparam int SHIFT_W = $clog2(vzd_pkg::VALUE_W) + 1;

   logic [vzd_pkg::VALUE_W-1:0] acc_ff;
   logic [vzd_pkg::VALUE_W-1:0] acc_in;
   logic                        signed_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [vzd_pkg::VALUE_W-1:0] value_ff;
   logic [vzd_pkg::COUNT_W-1:0] used_ff;
   vzd_pkg::reason_type         reason_ff;
   logic                        take;
   logic [SHIFT_W-1:0]          shift_amt;
   logic [vzd_pkg::VALUE_W-1:0] merged;
   logic [vzd_pkg::VALUE_W-1:0] result;

   // Continue bytes always drain; an ending byte needs a free result slot
   assign op_ready = !op.is_end || !rsp_valid_ff || rsp_ready;
   assign take     = op_valid && op_ready;

   // Merge payload at seven bits per position, dropping bits above the top
   assign shift_amt = SHIFT_W'(op.idx) * SHIFT_W'(vzd_pkg::PAYLOAD_W);
   assign merged    = acc_ff | (vzd_pkg::VALUE_W'(op.payload) << shift_amt);

   // Undo zigzag: halve and flip all bits when the low bit is set
   assign result = signed_ff
                 ? ({1'b0, merged[vzd_pkg::VALUE_W-1:1]} ^ {vzd_pkg::VALUE_W{merged[0]}})
                 : merged;

   always_comb begin
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (take) begin
         acc_in = op.is_end ? '0 : merged;
         if (op.is_end) begin
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         signed_ff    <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mode_wr) begin
            signed_ff <= mode_data;
         end
      end
   end

   // Load the result register on an ending byte
   always_ff @(posedge clock) begin
      if (take && op.is_end) begin
         value_ff  <= result;
         used_ff   <= op.idx + vzd_pkg::COUNT_W'(1);
         reason_ff <= op.reason;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = value_ff;
   assign rsp_used   = used_ff;
   assign rsp_reason = reason_ff;

endmodule

// ===== rtl/varint_zigzag_decoder.sv =====
// Path: an ending request is written into the queue, then taken by the back end
// into the result register, which offers the result.
// Throughput: one request per cycle while the back end is not stalled; the back
// end drains one classified byte per cycle from a two-entry queue and stalls
// only on a full result register.
// Reset: synchronous, active high; clears position, accumulator, queue,
// result valid and signed mode.
// ----------------------------------------------------------------------------
// varint_zigzag_decoder
// Little-endian base-128 varint decoder with optional zigzag decoding.
// ----------------------------------------------------------------------------
module varint_zigzag_decoder #(
   parameter int MAX_BYTES = vzd_pkg::MAX_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Requests
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // buffer_end
   // Results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [63:0] value, [67:64] bytes_used, [71:68] zero
   output logic [1:0]  rsp_tuser,   // [1:0] end_reason
   // Signed mode register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // signed_mode
);

   logic                        fq_valid;
   logic                        fq_ready;
   vzd_pkg::op_type             fq_op;
   logic                        qb_valid;
   logic                        qb_ready;
   vzd_pkg::op_type             qb_op;
   logic [vzd_pkg::VALUE_W-1:0] value;
   logic [vzd_pkg::COUNT_W-1:0] used;
   vzd_pkg::reason_type         reason;

   assign csr_ready = 1'b1;

   vzd_front #(
      .MAX_BYTES (MAX_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid),
      .byte_ready (req_tready),
      .data_byte  (req_tdata),
      .buffer_end (req_tlast),
      .op_valid   (fq_valid),
      .op_ready   (fq_ready),
      .op         (fq_op)
   );

   vzd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_op    (fq_op),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_op     (qb_op)
   );

   vzd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .op_valid   (qb_valid),
      .op_ready   (qb_ready),
      .op         (qb_op),
      .mode_wr    (csr_valid && csr_ready),
      .mode_data  (csr_data),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_value  (value),
      .rsp_used   (used),
      .rsp_reason (reason)
   );

   // Pack the result
   assign rsp_tdata = {4'b0, used, value};
   assign rsp_tuser = reason;

endmodule

// ===== rtl/vzd_checker.sv =====
// ----------------------------------------------------------------------------
// vzd_checker
// Port-level checks on the decoder's result stream.
// ----------------------------------------------------------------------------
module vzd_checker #(
   parameter int MAX_BYTES = vzd_pkg::MAX_BYTES_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // No result in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   // Byte count lies between one and the limit
   a_used_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[67:64] != 4'd0) && (rsp_tdata[67:64] <= 4'(MAX_BYTES)))
      else $error("bytes_used out of range");

   // A limit ending uses exactly the limit
   a_limit_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == vzd_pkg::END_LIMIT)
      |-> (rsp_tdata[67:64] == 4'(MAX_BYTES)))
      else $error("limit ending with wrong byte count");

   // Reason is a defined code and padding stays clear
   a_reason_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser == vzd_pkg::END_TERM) ||
                      (rsp_tuser == vzd_pkg::END_BUFFER) ||
                      (rsp_tuser == vzd_pkg::END_LIMIT)) && (rsp_tdata[71:68] == 4'd0))
      else $error("bad end reason or padding");

   // A stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind varint_zigzag_decoder vzd_checker #(
   .MAX_BYTES (MAX_BYTES)
) u_vzd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the varint zigzag decoder. Feeds byte streams of
// well-formed, truncated, over-long and noisy varints in both signed modes,
// predicts every decoded value in the bench and checks each response field
// by field, under random idling, long back-pressure and sender pauses.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VARINT_MAX   = vzd_pkg::MAX_BYTES_DEF;
   localparam int SETTLE_WAIT  = 6;     // cycles past the last response
   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int QUIET_LIMIT  = 3000;  // cycles with no handshake at all
   localparam int REPORT_LIMIT = 10;

   // One decoded varint as the bench expects it
   typedef struct {
      logic [vzd_pkg::VALUE_W-1:0] value;
      logic [vzd_pkg::COUNT_W-1:0] used;
      vzd_pkg::reason_type         why;
   } varint_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] data_byte
   logic        req_tlast;    // buffer_end
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;    // [63:0] value, [67:64] bytes_used, [71:68] zero
   logic [1:0]  rsp_tuser;    // [1:0] end_reason
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_data;     // signed_mode

   // Bench copy of the decoder state
   logic [vzd_pkg::VALUE_W-1:0] pending_value;
   logic [vzd_pkg::COUNT_W-1:0] pending_bytes;
   logic                        zigzag_on;
   varint_result_type           expected_varints[$];

   int  mismatches;
   int  bytes_taken;
   int  varints_checked;
   int  mode_writes;
   int  quiet_cycles;
   bit  idle_on;
   bit  hold_rsp;

   varint_zigzag_decoder #(
      .MAX_BYTES (VARINT_MAX)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Count a failure, report only the first few
   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("MISMATCH: %s", msg);
      end
   endtask

   // Fold one accepted byte into the predicted state, queue a result on the ending byte
   task automatic decode_byte(input logic [7:0] b, input logic last);
      int unsigned                 shift;
      logic [vzd_pkg::VALUE_W-1:0] part;
      logic [vzd_pkg::COUNT_W-1:0] used;
      varint_result_type           res;
      shift = pending_bytes * vzd_pkg::PAYLOAD_W;
      part  = {57'd0, b[vzd_pkg::PAYLOAD_W-1:0]} << shift;
      if (shift < vzd_pkg::VALUE_W) begin
         pending_value = pending_value | part;
      end
      used = pending_bytes + 4'd1;
      if (!b[vzd_pkg::CONT_BIT]) begin
         res.why = vzd_pkg::END_TERM;
      end else if (last) begin
         res.why = vzd_pkg::END_BUFFER;
      end else if (used >= VARINT_MAX) begin
         res.why = vzd_pkg::END_LIMIT;
      end else begin
         pending_bytes = used;
         return;
      end
      if (zigzag_on) begin
         res.value = (pending_value >> 1) ^ (64'd0 - {63'd0, pending_value[0]});
      end else begin
         res.value = pending_value;
      end
      res.used = used;
      expected_varints.insert(expected_varints.size(), res);
      pending_value = '0;
      pending_bytes = '0;
   endtask

   // Watch all three channels: predict on requests, check responses, run the watchdog
   always @(posedge clock) begin
      varint_result_type exp_res;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            zigzag_on = csr_data;
            mode_writes++;
         end
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata, req_tlast);
            bytes_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_varints.size() == 0) begin
               note_mismatch($sformatf("unexpected response value=%h used=%0d reason=%0d",
                                       rsp_tdata[63:0], rsp_tdata[67:64], rsp_tuser));
            end else begin
               exp_res = expected_varints.pop_front();
               varints_checked++;
               if (rsp_tdata[63:0] !== exp_res.value) begin
                  note_mismatch($sformatf("value expected %h got %h",
                                          exp_res.value, rsp_tdata[63:0]));
               end
               if (rsp_tdata[67:64] !== exp_res.used) begin
                  note_mismatch($sformatf("bytes_used expected %0d got %0d",
                                          exp_res.used, rsp_tdata[67:64]));
               end
               if (rsp_tdata[71:68] !== 4'd0) begin
                  note_mismatch($sformatf("tdata padding expected 0 got %h",
                                          rsp_tdata[71:68]));
               end
               if (rsp_tuser !== exp_res.why) begin
                  note_mismatch($sformatf("end_reason expected %0d got %0d",
                                          exp_res.why, rsp_tuser));
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Response side: random gaps, optional long hold-off
   initial begin
      int gap;
      rsp_tready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         gap = idle_on ? $urandom_range(0, 15) : 0;
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Offer one request after a random gap and hold it until taken
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = idle_on ? $urandom_range(0, 15) : 0;
      repeat (gap) @(negedge clock);
      req_tdata  = b;
      req_tlast  = last;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // Write the signed mode register
   task automatic write_signed_mode(input logic m);
      csr_data  = m;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Hold the sender until every expected response is in and the pipe has settled
   task automatic drain();
      while (expected_varints.size() != 0) @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
   endtask

   // Seven payload bits, biased towards the extremes
   function automatic logic [6:0] draw_payload();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return 7'h7F;
      if (pick == 1) return 7'h00;
      return 7'($urandom_range(0, 127));
   endfunction

   // One random varint: mostly well-formed, some truncated, over-long or noise
   task automatic send_varint();
      int kind;
      int len;
      kind = $urandom_range(0, 15);
      if (kind == 0) begin
         // stray byte, random flags
         send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
      end else if (kind == 1) begin
         // buffer runs out with continuation still set
         len = $urandom_range(1, VARINT_MAX);
         for (int i = 0; i < len; i++) begin
            send_byte({1'b1, draw_payload()}, (i == len - 1));
         end
      end else if (kind == 2) begin
         // never terminated: cut off at the byte limit
         for (int i = 0; i < VARINT_MAX; i++) begin
            send_byte({1'b1, draw_payload()}, 1'b0);
         end
      end else begin
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(4, VARINT_MAX)
                                           : $urandom_range(1, 3);
         for (int i = 0; i < len - 1; i++) begin
            send_byte({1'b1, draw_payload()}, 1'b0);
         end
         send_byte({1'b0, draw_payload()}, ($urandom_range(0, 3) == 0));
      end
   endtask

   // Extreme values and the end-condition priorities, unsigned mode
   task automatic test_directed_edges();
      idle_on = 1'b1;
      send_byte(8'h00, 1'b0);
      // terminator and buffer end on one byte: terminator wins
      send_byte(8'h7F, 1'b1);
      // ten bytes of all ones: top payload bits dropped, limit reached
      repeat (VARINT_MAX) send_byte(8'hFF, 1'b0);
      // buffer ends on a byte with continuation set
      send_byte(8'h81, 1'b1);
      // buffer end and byte limit on one byte: buffer end wins
      repeat (VARINT_MAX - 1) send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b1);
      drain();
   endtask

   // Switch to signed mode between bytes of one varint; the ending byte's mode applies
   task automatic test_mode_switch_mid_varint();
      send_byte(8'h81, 1'b0);
      drain();
      write_signed_mode(1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h02, 1'b0);
      drain();
   endtask

   // Random varint traffic in one mode
   task automatic test_random_traffic(input logic m, input bit idle, input int count);
      int target;
      drain();
      write_signed_mode(m);
      idle_on = idle;
      target  = bytes_taken + count;
      while (bytes_taken < target) send_varint();
      drain();
   endtask

   // Receiver stalls for a long stretch while single-byte varints keep coming
   task automatic test_backpressure();
      drain();
      idle_on  = 1'b0;
      hold_rsp = 1'b1;
      repeat (40) send_byte({1'b0, draw_payload()}, 1'b0);
      drain();
   endtask

   // Bursts separated by pauses in which everything drains
   task automatic test_sender_pause();
      idle_on = 1'b1;
      repeat (4) begin
         repeat (8) send_varint();
         drain();
      end
   endtask

   // Reset, then run the tests in turn
   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tlast     = 1'b0;
      csr_valid     = 1'b0;
      csr_data      = 1'b0;
      pending_value = '0;
      pending_bytes = '0;
      zigzag_on     = 1'b0;
      mismatches    = 0;
      bytes_taken   = 0;
      varints_checked = 0;
      mode_writes   = 0;
      quiet_cycles  = 0;
      idle_on       = 1'b1;
      hold_rsp      = 1'b0;
      repeat (7) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_directed_edges();
      test_mode_switch_mid_varint();
      test_random_traffic(1'b1, 1'b1, 300);
      test_random_traffic(1'b0, 1'b1, 300);
      test_backpressure();
      test_random_traffic(1'b1, 1'b0, 250);
      test_sender_pause();
      test_random_traffic(1'b0, 1'b0, 250);
      test_random_traffic(1'b1, 1'b1, 150);
      drain();

      // Anything still expected never arrived
      while (expected_varints.size() != 0) begin
         void'(expected_varints.pop_front());
         note_mismatch("expected response never arrived");
      end

      $display("Summary: %0d bytes in, %0d varints checked, %0d signed-mode writes.",
               bytes_taken, varints_checked, mode_writes);
      $display("Covered both modes, all end reasons, idle and back-pressure phases.");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
